[design/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and constants of the standby wake controller.
// ----------------------------------------------------------------------------
package swc_pkg;

    localparam int CFG_TIME_W   = 24;
    localparam int LEVEL_W      = 7;
    localparam int FRAME_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HOLD_TIME  = 3'd0;
    localparam t_cfg_idx CFG_BL_TIMEOUT = 3'd1;
    localparam t_cfg_idx CFG_CLR_TIMEOUT = 3'd2;
    localparam t_cfg_idx CFG_FRAME_PER  = 3'd3;
    localparam t_cfg_idx CFG_RUN_BRIGHT = 3'd4;

    localparam logic [CFG_TIME_W-1:0] HOLD_TIME_RST   = 24'd3000000;
    localparam logic [CFG_TIME_W-1:0] BL_TIMEOUT_RST  = 24'd3000000;
    localparam logic [CFG_TIME_W-1:0] CLR_TIMEOUT_RST = 24'd3000000;
    localparam logic [CFG_TIME_W-1:0] FRAME_PER_RST   = 24'd200000;
    localparam logic [LEVEL_W-1:0]    RUN_BRIGHT_RST  = 7'd100;
    localparam logic [LEVEL_W-1:0]    LEVEL_MAX       = 7'd100;

    localparam logic [7:0] BREATH_PERIOD = 8'd200;
    localparam logic [7:0] BREATH_LAST   = 8'd199;
    localparam logic [7:0] BREATH_FULL   = 8'd100;

    typedef enum logic [1:0] {
        BAT_CHARGING = 2'd0,
        BAT_CHARGED  = 2'd1,
        BAT_FAULT    = 2'd2
    } t_bat_status;

    typedef struct packed {
        logic                 led_on;
        logic                 wake_backlight;
        logic                 backlight_write;
        logic [LEVEL_W-1:0]   backlight_level;
        logic                 clear_screen;
        logic                 draw_battery;
        t_bat_status          battery_status;
        logic [FRAME_W-1:0]   frame_number;
        logic                 power_on_granted;
    } t_result;

endpackage

[design/swc_if.sv]
// ----------------------------------------------------------------------------
// swc_if
// Channel interfaces: poll items in, results out, configuration writes.
// ----------------------------------------------------------------------------
interface swc_in_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_us;
    logic                 enter_level;
    logic                 charge_pin;
    logic                 standby_pin;

    modport source (output valid, output now_us, output enter_level,
                    output charge_pin, output standby_pin, input ready);
    modport sink   (input valid, input now_us, input enter_level,
                    input charge_pin, input standby_pin, output ready);
endinterface

interface swc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              led_on;
    logic                              wake_backlight;
    logic                              backlight_write;
    logic [swc_pkg::LEVEL_W-1:0]       backlight_level;
    logic                              clear_screen;
    logic                              draw_battery;
    logic [1:0]                        battery_status;
    logic [swc_pkg::FRAME_W-1:0]       frame_number;
    logic                              power_on_granted;

    modport source (output valid, output led_on, output wake_backlight,
                    output backlight_write, output backlight_level,
                    output clear_screen, output draw_battery,
                    output battery_status, output frame_number,
                    output power_on_granted, input ready);
    modport sink   (input valid, input led_on, input wake_backlight,
                    input backlight_write, input backlight_level,
                    input clear_screen, input draw_battery,
                    input battery_status, input frame_number,
                    input power_on_granted, output ready);
endinterface

interface swc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [swc_pkg::CFG_IDX_W-1:0]  index;
    logic [swc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/swc_breath.sv]
// ----------------------------------------------------------------------------
// swc_breath
// Breathing LED: 200-step triangle phase into an accumulator that
// overflows at 100.
// ----------------------------------------------------------------------------
module swc_breath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    output logic o_led
);

    logic [7:0] r_phase;
    logic [7:0] n_phase;
    logic [6:0] r_acc;
    logic [6:0] n_acc;
    logic [7:0] tri_level;
    logic [7:0] sum;

    always_comb begin
        tri_level = (r_phase <= swc_pkg::BREATH_FULL) ? r_phase
                                                      : swc_pkg::BREATH_PERIOD - r_phase;
        sum   = {1'b0, r_acc} + tri_level;
        o_led = (sum >= swc_pkg::BREATH_FULL);
        n_acc = o_led ? 7'(sum - swc_pkg::BREATH_FULL) : 7'(sum);
        n_phase = (r_phase >= swc_pkg::BREATH_LAST) ? 8'd0 : r_phase + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_acc   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

[design/standby_wake_controller.sv]
// ----------------------------------------------------------------------------
// standby_wake_controller
// Standby poll loop: breathing LED, backlight/screen timeouts, battery frames
// and power-on grant after a long enter press.
// ----------------------------------------------------------------------------
// One poll item in gives one result item out. Every poll is decided in the
// cycle it is accepted and its result is held in an output register, so a
// new item is taken every clock as long as the result side keeps taking
// results. All timing is in the timestamps carried by the items, not in
// clock cycles. Configuration writes are taken at any time and apply from
// the next accepted item. After power-on is granted every further item
// returns only power_on_granted.
// ----------------------------------------------------------------------------
module standby_wake_controller #(
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swc_cfg_if.sink     i_cfg,
    swc_in_if.sink      i_item,
    swc_out_if.source   o_result
);

    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam int CW = swc_pkg::CFG_TIME_W;

    logic [CW-1:0]              r_hold_time;
    logic [CW-1:0]              r_bl_to;
    logic [CW-1:0]              r_clr_to;
    logic [CW-1:0]              r_frame_per;
    logic [swc_pkg::LEVEL_W-1:0] r_run_bright;

    logic                       r_armed;
    logic                       r_finished;
    logic                       r_holding;
    logic                       r_enter_prev;
    logic                       r_lit;
    logic                       r_shown;
    logic [TIME_BITS-1:0]       r_hold_start;
    logic [TIME_BITS-1:0]       r_bl_dl;
    logic [TIME_BITS-1:0]       r_clr_dl;
    logic [TIME_BITS-1:0]       r_frame_dl;
    logic [swc_pkg::FRAME_W-1:0] r_frame_cnt;

    logic                       r_out_valid;
    swc_pkg::t_result           r_res;
    swc_pkg::t_result           n_res;

    logic                       take;
    logic                       advance;
    logic                       led_raw;
    logic [TIME_BITS-1:0]       now;
    logic                       pressed;
    logic                       rearm;
    logic                       press_edge;
    logic [CW:0]                btct;
    logic [TIME_BITS:0]         sum_bl;
    logic [TIME_BITS:0]         sum_cl;
    logic [TIME_BITS:0]         sum_fr;
    logic [TIME_BITS-1:0]       bl_new;
    logic [TIME_BITS-1:0]       cl_new;
    logic [TIME_BITS-1:0]       fr_new;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       bl_due;
    logic                       cl_due;
    logic                       fr_due;
    logic                       grant;
    logic                       lit1;
    logic                       shown1;
    logic                       shown2;
    logic                       bl_off;
    logic                       clr;
    logic                       draw;
    swc_pkg::t_bat_status       bat;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign take         = i_item.valid && i_item.ready;
    assign advance      = take && !r_finished;

    swc_breath u_breath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .o_led     (led_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time  <= swc_pkg::HOLD_TIME_RST;
            r_bl_to      <= swc_pkg::BL_TIMEOUT_RST;
            r_clr_to     <= swc_pkg::CLR_TIMEOUT_RST;
            r_frame_per  <= swc_pkg::FRAME_PER_RST;
            r_run_bright <= swc_pkg::RUN_BRIGHT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                swc_pkg::CFG_HOLD_TIME:   r_hold_time  <= i_cfg.data;
                swc_pkg::CFG_BL_TIMEOUT:  r_bl_to      <= i_cfg.data;
                swc_pkg::CFG_CLR_TIMEOUT: r_clr_to     <= i_cfg.data;
                swc_pkg::CFG_FRAME_PER:   r_frame_per  <= i_cfg.data;
                swc_pkg::CFG_RUN_BRIGHT:  r_run_bright <= i_cfg.data[swc_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        now        = i_item.now_us;
        pressed    = !i_item.enter_level;
        press_edge = pressed && !r_enter_prev;
        rearm      = !r_armed || (pressed != r_enter_prev);

        // saturating deadline sums
        btct   = {1'b0, r_bl_to} + {1'b0, r_clr_to};
        sum_bl = {1'b0, now} + (TIME_BITS+1)'(r_bl_to);
        sum_cl = {1'b0, now} + (TIME_BITS+1)'(btct);
        sum_fr = {1'b0, now} + (TIME_BITS+1)'(r_frame_per);
        bl_new = sum_bl[TIME_BITS] ? TMAX : sum_bl[TIME_BITS-1:0];
        cl_new = sum_cl[TIME_BITS] ? TMAX : sum_cl[TIME_BITS-1:0];
        fr_new = sum_fr[TIME_BITS] ? TMAX : sum_fr[TIME_BITS-1:0];

        // a freshly armed deadline is due only for zero timeout or a maxed clock
        bl_due = rearm ? ((r_bl_to == '0) || (now == TMAX)) : (now >= r_bl_dl);
        cl_due = rearm ? ((btct == '0) || (now == TMAX)) : (now >= r_clr_dl);
        fr_due = press_edge || (now >= r_frame_dl);

        elapsed = now - r_hold_start;
        grant   = pressed && r_holding && (elapsed >= TIME_BITS'(r_hold_time));

        lit1   = r_lit || press_edge;
        shown1 = r_shown || press_edge;
        bl_off = !grant && lit1 && !pressed && bl_due;
        clr    = !grant && shown1 && !pressed && cl_due;
        shown2 = shown1 && !clr;
        draw   = !grant && shown2 && fr_due;

        if (i_item.charge_pin && i_item.standby_pin) begin
            bat = swc_pkg::BAT_FAULT;
        end else if (!i_item.standby_pin) begin
            bat = swc_pkg::BAT_CHARGED;
        end else begin
            bat = swc_pkg::BAT_CHARGING;
        end

        n_res = '0;
        if (r_finished) begin
            n_res.power_on_granted = 1'b1;
        end else begin
            n_res.led_on         = led_raw && !grant;
            n_res.wake_backlight = press_edge;
            n_res.clear_screen   = clr;
            if (grant) begin
                n_res.backlight_write  = 1'b1;
                n_res.backlight_level  = (r_run_bright > swc_pkg::LEVEL_MAX) ?
                                         swc_pkg::LEVEL_MAX : r_run_bright;
                n_res.power_on_granted = 1'b1;
            end else if (bl_off) begin
                n_res.backlight_write = 1'b1;
            end
            if (draw) begin
                n_res.draw_battery   = 1'b1;
                n_res.battery_status = bat;
                n_res.frame_number   = r_frame_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_finished   <= 1'b0;
            r_holding    <= 1'b0;
            r_enter_prev <= 1'b0;
            r_lit        <= 1'b1;
            r_shown      <= 1'b1;
            r_hold_start <= '0;
            r_bl_dl      <= '0;
            r_clr_dl     <= '0;
            r_frame_dl   <= '0;
            r_frame_cnt  <= '0;
        end else if (advance) begin
            r_armed      <= 1'b1;
            r_finished   <= grant;
            r_holding    <= pressed;
            r_enter_prev <= pressed;
            r_lit        <= lit1 && !bl_off;
            r_shown      <= shown2;
            if (pressed && !r_holding) begin
                r_hold_start <= now;
            end
            if (rearm) begin
                r_bl_dl  <= bl_new;
                r_clr_dl <= cl_new;
            end
            if (draw) begin
                r_frame_dl  <= fr_new;
                r_frame_cnt <= r_frame_cnt + 1'b1;
            end else if (press_edge) begin
                r_frame_dl <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.led_on           = r_res.led_on;
    assign o_result.wake_backlight   = r_res.wake_backlight;
    assign o_result.backlight_write  = r_res.backlight_write;
    assign o_result.backlight_level  = r_res.backlight_level;
    assign o_result.clear_screen     = r_res.clear_screen;
    assign o_result.draw_battery     = r_res.draw_battery;
    assign o_result.battery_status   = r_res.battery_status;
    assign o_result.frame_number     = r_res.frame_number;
    assign o_result.power_on_granted = r_res.power_on_granted;

endmodule

[dv/tb_standby_wake_controller.sv]
// ----------------------------------------------------------------------------
// tb_standby_wake_controller
// Checks the standby poll loop one poll at a time: the breathing LED,
// backlight and screen timeouts, battery frame requests and the power-on
// grant. A local copy of the poll behavior computes each result, and every
// result taken from the block is compared with it field by field. Directed
// corners come first, then randomized press sequences under several settings
// and idle mixes, an output stall, and the grant as the last step.
// ----------------------------------------------------------------------------
module tb_standby_wake_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import swc_pkg::*;

    localparam int TB_PERIOD    = 12;
    localparam int TB_TIME_BITS = 48;
    localparam logic [TB_TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [TB_TIME_BITS-1:0] now_us;
        logic                    enter_level;
        logic                    charge_pin;
        logic                    standby_pin;
    } t_poll;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swc_in_if #(.TIME_BITS(TB_TIME_BITS)) poll_ch ();
    swc_out_if                            res_ch ();
    swc_cfg_if                            cfg_ch ();

    standby_wake_controller #(
        .TIME_BITS(TB_TIME_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (poll_ch),
        .o_result (res_ch)
    );

    always #(TB_PERIOD / 2) i_clk = ~i_clk;

    // settings as the block holds them
    logic [CFG_TIME_W-1:0] cfg_hold, cfg_bl, cfg_clr, cfg_frame;
    logic [LEVEL_W-1:0]    cfg_bright;

    // poll loop state
    logic                    armed, granted, press_held, enter_was_down;
    logic                    bl_on, scr_on;
    logic [TB_TIME_BITS-1:0] press_t0, bl_due, clr_due, frame_due;
    logic [7:0]              frame_idx, breath_ph, breath_acc;

    t_result responses_due[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_off_left  = 0;
    int step_span      = 1;
    logic [TB_TIME_BITS-1:0] wall_us = '0;

    int mismatches      = 0;
    int polls_sent      = 0;
    int results_checked = 0;
    int draws_seen      = 0;
    int clears_seen     = 0;
    int settings_loaded = 0;

    function automatic logic [TB_TIME_BITS-1:0] sat_time(input logic [TB_TIME_BITS-1:0] a,
                                                        input logic [CFG_TIME_W-1:0] b);
        logic [TB_TIME_BITS:0] s;
        s = {1'b0, a} + {{(TB_TIME_BITS + 1 - CFG_TIME_W){1'b0}}, b};
        return s[TB_TIME_BITS] ? TIME_MAX : s[TB_TIME_BITS-1:0];
    endfunction

    function automatic void rearm_deadlines(input logic [TB_TIME_BITS-1:0] t);
        bl_due  = sat_time(t, cfg_bl);
        clr_due = sat_time(bl_due, cfg_clr);
    endfunction

    function automatic void reset_poll_loop();
        cfg_hold       = HOLD_TIME_RST;
        cfg_bl         = BL_TIMEOUT_RST;
        cfg_clr        = CLR_TIMEOUT_RST;
        cfg_frame      = FRAME_PER_RST;
        cfg_bright     = RUN_BRIGHT_RST;
        armed          = 1'b0;
        granted        = 1'b0;
        press_held     = 1'b0;
        enter_was_down = 1'b0;
        bl_on          = 1'b1;
        scr_on         = 1'b1;
        press_t0       = '0;
        bl_due         = '0;
        clr_due        = '0;
        frame_due      = '0;
        frame_idx      = '0;
        breath_ph      = '0;
        breath_acc     = '0;
    endfunction

    function automatic void apply_setting(input t_cfg_idx idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_HOLD_TIME:   cfg_hold   = value[CFG_TIME_W-1:0];
            CFG_BL_TIMEOUT:  cfg_bl     = value[CFG_TIME_W-1:0];
            CFG_CLR_TIMEOUT: cfg_clr    = value[CFG_TIME_W-1:0];
            CFG_FRAME_PER:   cfg_frame  = value[CFG_TIME_W-1:0];
            CFG_RUN_BRIGHT:  cfg_bright = value[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_result standby_response(input t_poll p);
        t_result                 r;
        logic                    pressed;
        logic [7:0]              tri_lvl;
        logic [8:0]              breath_tot;
        logic [TB_TIME_BITS-1:0] held_for;
        r = '0;
        if (granted) begin
            r.power_on_granted = 1'b1;
            return r;
        end
        pressed = ~p.enter_level;
        if (!armed) begin
            armed = 1'b1;
            rearm_deadlines(p.now_us);
        end

        tri_lvl    = (breath_ph <= BREATH_FULL) ? breath_ph : BREATH_PERIOD - breath_ph;
        breath_tot = {1'b0, breath_acc} + {1'b0, tri_lvl};
        if (breath_tot >= {1'b0, BREATH_FULL}) begin
            r.led_on   = 1'b1;
            breath_tot = breath_tot - {1'b0, BREATH_FULL};
        end
        breath_acc = breath_tot[7:0];
        breath_ph  = (breath_ph >= BREATH_LAST) ? 8'd0 : breath_ph + 8'd1;

        if (pressed != enter_was_down) begin
            enter_was_down = pressed;
            if (pressed) begin
                r.wake_backlight = 1'b1;
                bl_on            = 1'b1;
                scr_on           = 1'b1;
                frame_due        = '0;
            end
            rearm_deadlines(p.now_us);
        end

        if (pressed) begin
            held_for = p.now_us - press_t0;
            if (!press_held) begin
                press_held = 1'b1;
                press_t0   = p.now_us;
            end else if (held_for >= {{(TB_TIME_BITS - CFG_TIME_W){1'b0}}, cfg_hold}) begin
                granted            = 1'b1;
                r.led_on           = 1'b0;
                r.backlight_write  = 1'b1;
                r.backlight_level  = (cfg_bright > LEVEL_MAX) ? LEVEL_MAX : cfg_bright;
                r.power_on_granted = 1'b1;
                return r;
            end
        end else begin
            press_held = 1'b0;
        end

        if (bl_on && !pressed && p.now_us >= bl_due) begin
            bl_on             = 1'b0;
            r.backlight_write = 1'b1;
            r.backlight_level = '0;
        end

        if (scr_on && !pressed && p.now_us >= clr_due) begin
            scr_on         = 1'b0;
            r.clear_screen = 1'b1;
        end

        if (scr_on && p.now_us >= frame_due) begin
            r.draw_battery = 1'b1;
            if (p.charge_pin && p.standby_pin)
                r.battery_status = BAT_FAULT;
            else if (!p.standby_pin)
                r.battery_status = BAT_CHARGED;
            else
                r.battery_status = BAT_CHARGING;
            r.frame_number = frame_idx;
            frame_idx      = frame_idx + 8'd1;
            frame_due      = sat_time(p.now_us, cfg_frame);
        end
        return r;
    endfunction

    function automatic t_poll poll_at(input logic [TB_TIME_BITS-1:0] t, input logic enter,
                                      input logic chg, input logic stby);
        t_poll p;
        p.now_us      = t;
        p.enter_level = enter;
        p.charge_pin  = chg;
        p.standby_pin = stby;
        return p;
    endfunction

    function automatic int unsigned time_step();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return $urandom_range(0, 3);
        else if (roll < 90)
            return $urandom_range(0, step_span);
        return $urandom_range(0, 4 * step_span);
    endfunction

    // Press streaks never reach the hold time, so the block stays alive
    // until the grant test at the very end.
    function automatic t_poll compose_poll();
        t_poll       p;
        logic [63:0] noise;
        int unsigned roll;
        p.charge_pin  = 1'($urandom_range(0, 1));
        p.standby_pin = 1'($urandom_range(0, 1));
        roll          = $urandom_range(0, 99);
        if (roll < 8) begin
            noise         = {$urandom(), $urandom()};
            p.now_us      = noise[TB_TIME_BITS-1:0];
            p.enter_level = press_held ? 1'b1 : 1'($urandom_range(0, 1));
        end else if (press_held && cfg_hold != 0 && $urandom_range(0, 99) < 70) begin
            p.now_us      = press_t0 + $urandom_range(0, cfg_hold - 1);
            p.enter_level = 1'b0;
            wall_us       = p.now_us;
        end else begin
            wall_us       = wall_us + time_step();
            p.now_us      = wall_us;
            p.enter_level = press_held ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    task automatic check_response();
        t_result got, want;
        got.led_on           = res_ch.led_on;
        got.wake_backlight   = res_ch.wake_backlight;
        got.backlight_write  = res_ch.backlight_write;
        got.backlight_level  = res_ch.backlight_level;
        got.clear_screen     = res_ch.clear_screen;
        got.draw_battery     = res_ch.draw_battery;
        got.battery_status   = t_bat_status'(res_ch.battery_status);
        got.frame_number     = res_ch.frame_number;
        got.power_on_granted = res_ch.power_on_granted;
        results_checked++;
        if (got.draw_battery === 1'b1)
            draws_seen++;
        if (got.clear_screen === 1'b1)
            clears_seen++;
        if (responses_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no poll outstanding",
                                      results_checked));
            return;
        end
        want = responses_due.pop_front();
        check_field("led_on", 8'(got.led_on), 8'(want.led_on));
        check_field("wake_backlight", 8'(got.wake_backlight), 8'(want.wake_backlight));
        check_field("backlight_write", 8'(got.backlight_write), 8'(want.backlight_write));
        check_field("backlight_level", 8'(got.backlight_level), 8'(want.backlight_level));
        check_field("clear_screen", 8'(got.clear_screen), 8'(want.clear_screen));
        check_field("draw_battery", 8'(got.draw_battery), 8'(want.draw_battery));
        check_field("battery_status", 8'(got.battery_status), 8'(want.battery_status));
        check_field("frame_number", got.frame_number, want.frame_number);
        check_field("power_on_granted", 8'(got.power_on_granted),
                    8'(want.power_on_granted));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            check_response();
    end

    // result side: long hold-off when requested, random stalls otherwise
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_off_left--;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_poll(input t_poll p);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            poll_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        poll_ch.valid       <= 1'b1;
        poll_ch.now_us      <= p.now_us;
        poll_ch.enter_level <= p.enter_level;
        poll_ch.charge_pin  <= p.charge_pin;
        poll_ch.standby_pin <= p.standby_pin;
        do @(posedge i_clk); while (poll_ch.ready !== 1'b1);
        responses_due.push_back(standby_response(p));
        polls_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        poll_ch.valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_setting(idx, value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] hold, bl, clr, frame, bright);
        settle();
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_BL_TIMEOUT, bl);
        write_reg(CFG_CLR_TIMEOUT, clr);
        write_reg(CFG_FRAME_PER, frame);
        write_reg(CFG_RUN_BRIGHT, bright);
        settings_loaded++;
    endtask

    task automatic run_poll_mix(input int n, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        step_span      = (int'(cfg_bl) + int'(cfg_clr)) / 16 + int'(cfg_frame) / 2 + 1;
        repeat (n) send_poll(compose_poll());
    endtask

    // reset settings, first-item arming, pin decode, deadline saturation,
    // wrapped hold time, zero timeouts, writes to unused indexes
    task automatic test_directed_corners();
        int idx;
        send_poll(poll_at(48'd0, 1'b1, 1'b0, 1'b0));
        send_poll(poll_at(48'd199999, 1'b1, 1'b1, 1'b0));
        send_poll(poll_at(48'd200000, 1'b1, 1'b0, 1'b1));
        send_poll(poll_at(48'd2999999, 1'b1, 1'b1, 1'b1));
        send_poll(poll_at(48'd3000000, 1'b1, 1'b0, 1'b1));
        send_poll(poll_at(48'd6000000, 1'b1, 1'b1, 1'b1));
        send_poll(poll_at(48'd6000001, 1'b0, 1'b1, 1'b1));
        send_poll(poll_at(48'd6000002, 1'b1, 1'b0, 1'b0));

        load_settings(24'd1000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
        send_poll(poll_at(TIME_MAX - 48'd10, 1'b0, 1'b1, 1'b0));
        send_poll(poll_at(48'd5, 1'b0, 1'b0, 1'b1));
        send_poll(poll_at(TIME_MAX, 1'b1, 1'b1, 1'b1));

        load_settings(24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd55);
        for (idx = CFG_RUN_BRIGHT + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(t_cfg_idx'(idx), 24'($urandom()));
        send_poll(poll_at(48'd100, 1'b0, 1'b0, 1'b0));
        send_poll(poll_at(48'd100, 1'b1, 1'b1, 1'b0));
        send_poll(poll_at(48'd101, 1'b1, 1'b0, 1'b1));
        send_poll(poll_at(48'd102, 1'b0, 1'b1, 1'b1));
        send_poll(poll_at(48'd103, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_default_settings();
        load_settings(HOLD_TIME_RST, BL_TIMEOUT_RST, CLR_TIMEOUT_RST, FRAME_PER_RST,
                      24'(RUN_BRIGHT_RST));
        wall_us = 48'd1000;
        run_poll_mix(150, 0, 0);
    endtask

    task automatic test_short_timeouts();
        load_settings(24'd40, 24'd30, 24'd20, 24'd7, 24'd1);
        run_poll_mix(150, 55, 0);
    endtask

    task automatic test_zero_settings();
        load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd100);
        run_poll_mix(150, 0, 55);
    endtask

    task automatic test_max_settings();
        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd127);
        run_poll_mix(150, 34, 34);
    endtask

    task automatic test_random_settings();
        int pass;
        for (pass = 0; pass < 3; pass++) begin
            load_settings(24'($urandom_range(0, 1 << $urandom_range(0, 23))),
                          24'($urandom_range(0, 1 << $urandom_range(0, 23))),
                          24'($urandom_range(0, 1 << $urandom_range(0, 23))),
                          24'($urandom_range(0, 1 << $urandom_range(0, 23))),
                          24'($urandom_range(0, 127)));
            run_poll_mix(50, (pass == 1) ? 34 : 0, (pass == 2) ? 55 : 34);
        end
    endtask

    // output held off while polls keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        settle();
        hold_off_left = 250;
        run_poll_mix(120, 0, 0);
    endtask

    // hold time measured across the timestamp wrap; one short of the hold,
    // then exactly on it; brightness written above range; later polls ignored
    task automatic test_power_on_grant();
        t_poll p;
        int    n;
        settle();
        write_reg(CFG_HOLD_TIME, 24'd20);
        write_reg(CFG_RUN_BRIGHT, 24'hFFFFFF);
        settings_loaded++;
        src_idle_pct   = 34;
        sink_stall_pct = 34;
        send_poll(poll_at(wall_us, 1'b1, 1'b0, 1'b1));
        send_poll(poll_at(TIME_MAX - 48'd4, 1'b0, 1'b1, 1'b0));
        send_poll(poll_at(48'd14, 1'b0, 1'b0, 1'b1));
        send_poll(poll_at(48'd15, 1'b0, 1'b1, 1'b1));
        for (n = 0; n < 5; n++) begin
            p = compose_poll();
            p.enter_level = n[0];
            send_poll(p);
        end
    endtask

    initial begin
        #(TB_PERIOD * 400000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        reset_poll_loop();
        i_rst_n             = 1'b0;
        poll_ch.valid       = 1'b0;
        poll_ch.now_us      = '0;
        poll_ch.enter_level = 1'b1;
        poll_ch.charge_pin  = 1'b0;
        poll_ch.standby_pin = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_default_settings();
        test_short_timeouts();
        test_zero_settings();
        test_max_settings();
        test_random_settings();
        test_output_backpressure();
        test_power_on_grant();

        settle();
        repeat (8) @(posedge i_clk);
        $display("Polls sent: %0d, results checked: %0d, across %0d register settings.",
                 polls_sent, results_checked, settings_loaded);
        $display("Battery frames drawn: %0d, screen clears: %0d, mismatches: %0d.",
                 draws_seen, clears_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[standby_wake_controller.f]
design/swc_pkg.sv
design/swc_if.sv
design/swc_breath.sv
design/standby_wake_controller.sv
dv/tb_standby_wake_controller.sv
